// File: src/fcp_pkg.sv
package fcp_pkg;

  localparam int unsigned NUM_FUNCS = 4096;
  localparam int unsigned IDX_W     = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned TS_W      = 64;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 32;

  localparam logic [ADDR_W-1:0]    NUM_FUNCS_W = ADDR_W'(NUM_FUNCS);
  localparam logic [IDX_W-1:0]     LAST_IDX    = IDX_W'(NUM_FUNCS - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 1'b1;

  typedef enum logic [1:0] {
    OP_ENTER = 2'd0,
    OP_EXIT  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } fcp_op_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_DISABLED = 3'd1,
    ST_OPEN     = 3'd2,
    ST_NOT_OPEN = 3'd3,
    ST_RANGE    = 3'd4
  } fcp_status_e;

  // What the back end has to do with a beat, decided in the front end.
  typedef enum logic [2:0] {
    K_ENTER    = 3'd0,
    K_EXIT     = 3'd1,
    K_READ     = 3'd2,
    K_CLEAR    = 3'd3,
    K_DISABLED = 3'd4,
    K_RANGE    = 3'd5
  } fcp_kind_e;

  typedef struct packed {
    fcp_op_e           operation;
    logic [ADDR_W-1:0] func_addr;
    logic [TS_W-1:0]   timestamp;
  } fcp_in_t;

  typedef struct packed {
    fcp_status_e     status;
    logic [TS_W-1:0] total_cycles;
  } fcp_out_t;

  typedef struct packed {
    fcp_kind_e        kind;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [TS_W-1:0]  timestamp;
  } fcp_entry_t;

endpackage

// File: src/fcp_front.sv
module fcp_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fcp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fcp_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  fcp_pkg::fcp_in_t                  in_data_i,
  output fcp_pkg::fcp_entry_t               entry_o
);
  import fcp_pkg::*;

  logic              enabled_q, enabled_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [ADDR_W-1:0] idx_full;
  logic              in_range;

  always_comb begin
    enabled_d = enabled_q;
    base_d    = base_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ENABLED: enabled_d = cfg_wdata_i[0];
        CFG_BASE:    base_d    = cfg_wdata_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      base_q    <= '0;
    end else begin
      enabled_q <= enabled_d;
      base_q    <= base_d;
    end
  end

  // The index wraps modulo 2^32, as the address arithmetic does.
  assign idx_full = in_data_i.func_addr - base_q;
  assign in_range = idx_full < NUM_FUNCS_W;

  always_comb begin
    entry_o.in_range  = in_range;
    entry_o.idx       = idx_full[IDX_W-1:0];
    entry_o.timestamp = in_data_i.timestamp;
    case (in_data_i.operation)
      OP_CLEAR: entry_o.kind = K_CLEAR;
      OP_ENTER: entry_o.kind = !enabled_q ? K_DISABLED : (in_range ? K_ENTER : K_RANGE);
      OP_EXIT:  entry_o.kind = !enabled_q ? K_DISABLED : (in_range ? K_EXIT : K_RANGE);
      OP_READ:  entry_o.kind = in_range ? K_READ : K_RANGE;
      default:  entry_o.kind = K_RANGE;
    endcase
  end

endmodule

// File: src/fcp_queue.sv
module fcp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  fcp_pkg::fcp_entry_t  data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output fcp_pkg::fcp_entry_t  data_o
);
  import fcp_pkg::*;

  fcp_entry_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: src/fcp_back.sv
module fcp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  fcp_pkg::fcp_entry_t  q_data_i,
  output logic                 q_pop_o,
  output logic                 init_done_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fcp_pkg::fcp_out_t    out_data_o
);
  import fcp_pkg::*;

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_SUM   = 5'b01000,
    S_CLEAR = 5'b10000
  } fcp_state_e;

  fcp_state_e       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  fcp_entry_t       cur_q, cur_d;
  logic [TS_W-1:0]  diff_q, diff_d;
  logic             out_valid_q, out_valid_d;
  fcp_out_t         out_q, out_d;

  logic [TS_W-1:0]  start_mem [NUM_FUNCS];
  logic [TS_W-1:0]  total_mem [NUM_FUNCS];
  logic [TS_W-1:0]  start_rd_q, total_rd_q;

  logic             rd_en;
  logic             st_we, tot_we;
  logic [IDX_W-1:0] waddr;
  logic [TS_W-1:0]  st_wdata, tot_wdata;
  logic [TS_W-1:0]  sum;
  logic             out_free;
  logic             commit;
  fcp_out_t         res;

  assign out_free    = !out_valid_q || out_ready_i;
  assign sum         = total_rd_q + diff_q;
  assign init_done_o = state_q != S_INIT;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Result and table updates of the final step.
  always_comb begin
    res.status       = ST_DONE;
    res.total_cycles = total_rd_q;
    st_wdata         = cur_q.timestamp;
    tot_wdata        = sum;
    st_we            = 1'b0;
    tot_we           = 1'b0;
    case (cur_q.kind)
      K_ENTER: begin
        if (start_rd_q != '0) begin
          res.status = ST_OPEN;
        end else begin
          st_we = 1'b1;
        end
      end
      K_EXIT: begin
        if (start_rd_q == '0) begin
          res.status = ST_NOT_OPEN;
        end else begin
          st_wdata         = '0;
          st_we            = 1'b1;
          tot_we           = 1'b1;
          res.total_cycles = sum;
        end
      end
      K_READ: ;
      K_CLEAR: res.total_cycles = '0;
      K_DISABLED: begin
        res.status = ST_DISABLED;
        if (!cur_q.in_range) begin
          res.total_cycles = '0;
        end
      end
      default: begin
        res.status       = ST_RANGE;
        res.total_cycles = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    diff_d      = diff_q;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    rd_en       = 1'b0;
    commit      = 1'b0;
    waddr       = cur_q.idx;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_INIT, S_CLEAR: begin
        waddr = cnt_q;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          cnt_d   = '0;
          state_d = (state_q == S_INIT) ? S_IDLE : S_SUM;
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          rd_en   = 1'b1;
          cur_d   = q_data_i;
          cnt_d   = '0;
          state_d = (q_data_i.kind == K_CLEAR) ? S_CLEAR : S_READ;
        end
      end
      S_READ: begin
        diff_d  = cur_q.timestamp - start_rd_q;
        state_d = S_SUM;
      end
      S_SUM: begin
        if (out_free) begin
          commit      = 1'b1;
          out_d       = res;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    diff_q <= diff_d;
    out_q  <= out_d;
  end

  // Both tables share one write address: the sweep counter while zeroing,
  // the current entry's index otherwise.
  logic sweep;
  assign sweep = (state_q == S_INIT) || (state_q == S_CLEAR);

  always_ff @(posedge clk_i) begin
    if (sweep || (commit && st_we)) begin
      start_mem[waddr] <= sweep ? '0 : st_wdata;
    end
    if (rd_en) begin
      start_rd_q <= start_mem[q_data_i.idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sweep || (commit && tot_we)) begin
      total_mem[waddr] <= sweep ? '0 : tot_wdata;
    end
    if (rd_en) begin
      total_rd_q <= total_mem[q_data_i.idx];
    end
  end

endmodule

// File: src/function_cycle_profiler.sv
// Per-function cycle profiler. Each beat names a function by address; the
// address minus the base_address register selects one of NUM_FUNCS entries,
// each holding an open start time and an accumulated cycle total (a start of
// zero means none is open). Enter opens a start unless one is already open,
// exit adds the elapsed time to the total modulo 2^64 and closes the start,
// read returns the total, and clear zeroes both tables. Every input beat
// yields exactly one result beat with a status and the function's total.
// Enter, exit and read pass through the execution unit as a table read, an
// elapsed-time subtract, and an accumulate and write back; a beat starts
// only once the last has written back, and the write back waits while a
// result is still untaken. A clear walks both tables one entry a cycle.
// After reset the same walk runs, during which in_ready_o stays low;
// configuration writes are taken at any time.
module function_cycle_profiler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: index 0 is enabled, index 1 is base_address.
  input  logic                          cfg_we_i,
  input  logic [fcp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fcp_pkg::CFG_W-1:0]     cfg_wdata_i,
  // Input channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  fcp_pkg::fcp_in_t              in_data_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output fcp_pkg::fcp_out_t             out_data_o
);
  import fcp_pkg::*;

  fcp_entry_t front_entry;
  fcp_entry_t q_data;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  logic       init_done;
  logic       push;

  // The front end classifies each beat against the configuration so the
  // execution unit only has to look at the kind and the table index.
  fcp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .entry_o     (front_entry)
  );

  // Beats are held off until the power-up table walk has finished.
  assign in_ready_o = init_done && !q_full;
  assign push       = in_valid_i && in_ready_o;

  // A two-entry queue decouples intake from execution.
  fcp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  // The execution unit owns both tables and the result register, which lets
  // it read and prepare the next beat while a result still waits to be taken;
  // the write back of that beat waits until the result register is free.
  fcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .init_done_o (init_done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
